/* src/pps_pkg.sv */
// Shared types and constants of the preemptive priority scheduler.
package pps_pkg;

  localparam int CMD_W       = 2;
  localparam int SLOT_W      = 4;
  localparam int PORT_TIME_W = 16;
  localparam int PRIO_W      = 8;
  localparam int PCNT_W      = 5;

  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD    = 2'd0,
    CMD_TICK    = 2'd1,
    CMD_RESTART = 2'd2,
    CMD_NOP     = 2'd3
  } cmd_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic take;
    logic apply;
    logic scan;
    logic fetch;
    logic calc;
    logic wait_step;
    logic turn;
  } dp_ctl_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic is_tick;
    logic scan_last;
    logic found;
  } dp_stat_t;

endpackage

/* src/preemptive_priority_scheduler_core.sv */
// Top level of the preemptive priority scheduler: controller plus datapath.
//
//   Channel  Ports                                    Handshake
//   input    in_command in_slot in_arrival in_burst   start & !busy
//            in_prio
//   result   out_ran out_running_slot out_finished    out_strobe, one cycle
//            out_wait_ticks out_turnaround_ticks
//            out_all_done out_clock_now
//   config   cfg_wr_data (process_count)              cfg_wr_en
//
// Every transaction walks the whole table, one slot a cycle through the RAM
// read port, so its length is set by MAX_PROCS.
// A tick that finds a ready process goes on through the fetch, calc, wait and
// turn states before its report; an idle tick reports after the fetch, and
// loads, restarts and no-ops report straight after the scan. Each result is
// shown in the cycle before busy drops.
// Reset is synchronous and active low; no clearing pass is needed.
// The receiver cannot stall: each result is shown for exactly one cycle.
module preemptive_priority_scheduler_core import pps_pkg::*; #(
  parameter int MAX_PROCS = 16,
  parameter int TIME_BITS = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  output logic                   busy,
  input  logic [CMD_W-1:0]       in_command,
  input  logic [SLOT_W-1:0]      in_slot,
  input  logic [PORT_TIME_W-1:0] in_arrival,
  input  logic [PORT_TIME_W-1:0] in_burst,
  input  logic [PRIO_W-1:0]      in_prio,
  output logic                   out_strobe,
  output logic                   out_ran,
  output logic [SLOT_W-1:0]      out_running_slot,
  output logic                   out_finished,
  output logic [PORT_TIME_W-1:0] out_wait_ticks,
  output logic [PORT_TIME_W-1:0] out_turnaround_ticks,
  output logic                   out_all_done,
  output logic [PORT_TIME_W-1:0] out_clock_now,
  input  logic                   cfg_wr_en,
  input  logic [PCNT_W-1:0]      cfg_wr_data
);

  dp_ctl_t  ctl;
  dp_stat_t stat;

  pps_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .stat       (stat),
    .busy       (busy),
    .out_strobe (out_strobe),
    .ctl        (ctl)
  );

  pps_datapath #(
    .MAX_PROCS (MAX_PROCS),
    .TIME_BITS (TIME_BITS)
  ) u_datapath (
    .clk                  (clk),
    .rst_n                (rst_n),
    .ctl                  (ctl),
    .stat                 (stat),
    .in_command           (in_command),
    .in_slot              (in_slot),
    .in_arrival           (in_arrival),
    .in_burst             (in_burst),
    .in_prio              (in_prio),
    .cfg_wr_en            (cfg_wr_en),
    .cfg_wr_data          (cfg_wr_data),
    .out_ran              (out_ran),
    .out_running_slot     (out_running_slot),
    .out_finished         (out_finished),
    .out_wait_ticks       (out_wait_ticks),
    .out_turnaround_ticks (out_turnaround_ticks),
    .out_all_done         (out_all_done),
    .out_clock_now        (out_clock_now)
  );

  // A result only appears inside a transaction
  a_strobe_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> busy)
    else $error("result strobe outside a transaction");

  // One result per transaction: the strobe is high only while the controller is in its report state
  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |=> !out_strobe)
    else $error("result strobe held for more than one cycle");

  // A completion is always reported together with a run
  a_finish_ran: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_finished) |-> out_ran)
    else $error("finished reported without a running process");

  // No result in the cycle straight after a transaction is taken
  a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (busy && !out_strobe))
    else $error("result strobed too early after acceptance");

endmodule

/* src/pps_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module pps_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* src/pps_ctrl.sv */
// Controller state machine sequencing one transaction through the datapath.
module pps_ctrl import pps_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  input  dp_stat_t stat,
  output logic     busy,
  output logic     out_strobe,
  output dp_ctl_t  ctl
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_APPLY,
    S_SCAN,
    S_FETCH,
    S_CALC,
    S_WAIT,
    S_TURN,
    S_REPORT
  } state_t;

  state_t state_r, state_nxt;
  logic   busy_r;
  logic   strobe_r;

  // Next-state logic
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) state_nxt = S_APPLY;
      end
      S_APPLY: state_nxt = S_SCAN;
      S_SCAN: begin
        if (stat.scan_last) state_nxt = stat.is_tick ? S_FETCH : S_REPORT;
      end
      S_FETCH: state_nxt = stat.found ? S_CALC : S_REPORT;
      S_CALC:   state_nxt = S_WAIT;
      S_WAIT:   state_nxt = S_TURN;
      S_TURN:   state_nxt = S_REPORT;
      S_REPORT: state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  // Decode datapath commands from the state
  always_comb begin
    ctl           = '0;
    ctl.take      = (state_r == S_IDLE) && start;
    ctl.apply     = (state_r == S_APPLY);
    ctl.scan      = (state_r == S_SCAN);
    ctl.fetch     = (state_r == S_FETCH);
    ctl.calc      = (state_r == S_CALC);
    ctl.wait_step = (state_r == S_WAIT);
    ctl.turn      = (state_r == S_TURN);
  end

  // Hold state and registered handshake outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      busy_r   <= 1'b0;
      strobe_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      busy_r   <= (state_nxt != S_IDLE);
      strobe_r <= (state_nxt == S_REPORT);
    end
  end

  assign busy       = busy_r;
  assign out_strobe = strobe_r;

endmodule

/* src/pps_datapath.sv */
// Datapath: process table, scan comparators, clock and finish-time arithmetic.
module pps_datapath import pps_pkg::*; #(
  parameter int MAX_PROCS = 16,
  parameter int TIME_BITS = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  dp_ctl_t                ctl,
  output dp_stat_t               stat,
  input  logic [CMD_W-1:0]       in_command,
  input  logic [SLOT_W-1:0]      in_slot,
  input  logic [PORT_TIME_W-1:0] in_arrival,
  input  logic [PORT_TIME_W-1:0] in_burst,
  input  logic [PRIO_W-1:0]      in_prio,
  input  logic                   cfg_wr_en,
  input  logic [PCNT_W-1:0]      cfg_wr_data,
  output logic                   out_ran,
  output logic [SLOT_W-1:0]      out_running_slot,
  output logic                   out_finished,
  output logic [PORT_TIME_W-1:0] out_wait_ticks,
  output logic [PORT_TIME_W-1:0] out_turnaround_ticks,
  output logic                   out_all_done,
  output logic [PORT_TIME_W-1:0] out_clock_now
);

  localparam int AW = $clog2(MAX_PROCS);
  localparam int CW = $clog2(MAX_PROCS + 1);
  localparam int TB = TIME_BITS;
  localparam logic [CW-1:0] N_SLOTS = CW'(MAX_PROCS);
  localparam logic [TB-1:0] TMAX    = '1;

  // Captured transaction
  cmd_t              cmd_r;
  logic [SLOT_W-1:0] slot_r;
  logic              slot_ok_r;
  logic [TB-1:0]     arr_r;
  logic [TB-1:0]     burst_r;
  logic [PRIO_W-1:0] prio_r;
  logic [TB-1:0]     now_r;

  // Scheduler state
  logic [PCNT_W-1:0]    pc_r;
  logic [TB-1:0]        clock_r;
  logic                 have_cur_r;
  logic [AW-1:0]        cur_r;
  logic [MAX_PROCS-1:0] work_r;   // slot has remaining work
  logic [MAX_PROCS-1:0] fresh_r;  // remaining work equals burst
  logic [MAX_PROCS-1:0] nzb_r;    // burst is non-zero

  // Scan pipeline and accumulators
  logic [CW-1:0]     scan_idx_r;
  logic              pv_r;
  logic [AW-1:0]     pidx_r;
  logic              min_found_r;
  logic [AW-1:0]     min_i_r;
  logic [PRIO_W-1:0] min_p_r;
  logic              cur_elig_r;
  logic [PRIO_W-1:0] cur_p_r;
  logic [1:0]        cnt_r;

  // Update and result registers
  logic [AW-1:0] best_r;
  logic          ran_r;
  logic          fin_r;
  logic [TB:0]   sub_r;
  logic [TB-1:0] bst_r;
  logic [TB-1:0] wait_r;
  logic [TB-1:0] turn_r;

  // RAM ports
  logic [AW-1:0]     saddr;
  logic              load_wr;
  logic [AW-1:0]     arr_raddr;
  logic [AW-1:0]     rb_raddr;
  logic [TB-1:0]     arr_rd;
  logic [TB-1:0]     burst_rd;
  logic [PRIO_W-1:0] prio_rd;
  logic [TB-1:0]     rem_rd;

  // Combinational helpers
  logic          take_cur;
  logic          found;
  logic [AW-1:0] best_sel;
  logic          in_use;
  logic          has_work;
  logic          elig;
  logic [TB-1:0] rem_cur;
  logic [TB-1:0] rem_new;
  logic          fin_c;
  logic [TB:0]   fin_time;
  logic [TB+1:0] diff;
  logic [TB-1:0] wait_val;
  logic [TB:0]   turn_sum;
  logic [TB-1:0] turn_val;

  // Process table memories
  pps_ram #(.WIDTH(TB), .DEPTH(MAX_PROCS)) u_arr_ram (
    .clk(clk), .we(load_wr), .waddr(saddr), .wdata(arr_r),
    .raddr(arr_raddr), .rdata(arr_rd)
  );

  pps_ram #(.WIDTH(TB), .DEPTH(MAX_PROCS)) u_burst_ram (
    .clk(clk), .we(load_wr), .waddr(saddr), .wdata(burst_r),
    .raddr(rb_raddr), .rdata(burst_rd)
  );

  pps_ram #(.WIDTH(PRIO_W), .DEPTH(MAX_PROCS)) u_prio_ram (
    .clk(clk), .we(load_wr), .waddr(saddr), .wdata(prio_r),
    .raddr(scan_idx_r[AW-1:0]), .rdata(prio_rd)
  );

  pps_ram #(.WIDTH(TB), .DEPTH(MAX_PROCS)) u_rem_ram (
    .clk(clk), .we(ctl.calc), .waddr(best_r), .wdata(rem_new),
    .raddr(rb_raddr), .rdata(rem_rd)
  );

  // Load write and choice of the winner
  always_comb begin
    saddr     = AW'(slot_r);
    load_wr   = ctl.apply && (cmd_r == CMD_LOAD) && slot_ok_r;
    take_cur  = cur_elig_r && !(min_p_r < cur_p_r);
    found     = cur_elig_r || min_found_r;
    best_sel  = take_cur ? cur_r : min_i_r;
    arr_raddr = ctl.fetch ? best_sel : scan_idx_r[AW-1:0];
    rb_raddr  = ctl.fetch ? best_sel : best_r;
  end

  // Eligibility of the slot whose table data is on the read ports
  always_comb begin
    in_use   = 32'(pidx_r) < 32'(pc_r);
    has_work = pv_r && in_use && work_r[pidx_r];
    elig     = has_work && (arr_rd <= clock_r);
  end

  // Work unit and finish-time arithmetic
  always_comb begin
    rem_cur  = fresh_r[best_r] ? burst_rd : rem_rd;
    rem_new  = rem_cur - TB'(1);
    fin_c    = (rem_cur == TB'(1));
    fin_time = {1'b0, now_r} + (TB+1)'(1);
    diff     = {1'b0, fin_time} - {1'b0, sub_r};
    if (diff[TB+1]) begin
      wait_val = '0;
    end else if (diff[TB]) begin
      wait_val = TMAX;
    end else begin
      wait_val = diff[TB-1:0];
    end
    turn_sum = {1'b0, wait_r} + {1'b0, bst_r};
    turn_val = turn_sum[TB] ? TMAX : turn_sum[TB-1:0];
  end

  // Scheduler state with reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r       <= PCNT_W'(1);
      clock_r    <= '0;
      have_cur_r <= 1'b0;
      cur_r      <= '0;
      work_r     <= '0;
      fresh_r    <= '0;
      nzb_r      <= '0;
      pv_r       <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        pc_r <= cfg_wr_data;
      end
      // Apply a load or a restart before the scan
      if (ctl.apply) begin
        pv_r <= 1'b0;
        unique case (cmd_r)
          CMD_LOAD: begin
            if (slot_ok_r) begin
              fresh_r[saddr] <= 1'b1;
              work_r[saddr]  <= (burst_r != '0);
              nzb_r[saddr]   <= (burst_r != '0);
            end
          end
          CMD_RESTART: begin
            clock_r    <= '0;
            have_cur_r <= 1'b0;
            cur_r      <= '0;
            fresh_r    <= '1;
            work_r     <= nzb_r;
          end
          default: ;
        endcase
      end
      if (ctl.scan) begin
        pv_r <= (scan_idx_r < N_SLOTS);
      end
      // Advance the clock; drop the current process when nothing runs
      if (ctl.fetch) begin
        if (clock_r != TMAX) clock_r <= clock_r + TB'(1);
        if (!found) begin
          have_cur_r <= 1'b0;
          cur_r      <= '0;
        end
      end
      // Retire one work unit of the winner
      if (ctl.calc) begin
        fresh_r[best_r] <= 1'b0;
        if (fin_c) begin
          work_r[best_r] <= 1'b0;
          have_cur_r     <= 1'b0;
          cur_r          <= '0;
        end else begin
          have_cur_r <= 1'b1;
          cur_r      <= best_r;
        end
      end
    end
  end

  // Transaction capture, scan accumulators and results
  always_ff @(posedge clk) begin
    if (ctl.take) begin
      cmd_r     <= cmd_t'(in_command);
      slot_r    <= in_slot;
      slot_ok_r <= 32'(in_slot) < MAX_PROCS;
      arr_r     <= TB'(in_arrival);
      burst_r   <= TB'(in_burst);
      prio_r    <= in_prio;
      now_r     <= clock_r;
    end
    if (ctl.apply) begin
      scan_idx_r  <= '0;
      min_found_r <= 1'b0;
      cur_elig_r  <= 1'b0;
      cnt_r       <= '0;
      best_r      <= '0;
      ran_r       <= 1'b0;
      fin_r       <= 1'b0;
      wait_r      <= '0;
      turn_r      <= '0;
    end
    // Walk the table one slot a cycle
    if (ctl.scan) begin
      if (scan_idx_r < N_SLOTS) scan_idx_r <= scan_idx_r + CW'(1);
      pidx_r <= scan_idx_r[AW-1:0];
      if (elig && (!min_found_r || (prio_rd < min_p_r))) begin
        min_found_r <= 1'b1;
        min_i_r     <= pidx_r;
        min_p_r     <= prio_rd;
      end
      if (elig && have_cur_r && (pidx_r == cur_r)) begin
        cur_elig_r <= 1'b1;
        cur_p_r    <= prio_rd;
      end
      if (has_work && (cnt_r != 2'd2)) cnt_r <= cnt_r + 2'd1;
    end
    if (ctl.fetch && found) begin
      best_r <= best_sel;
      ran_r  <= 1'b1;
    end
    if (ctl.calc) begin
      fin_r <= fin_c;
      sub_r <= {1'b0, arr_rd} + {1'b0, burst_rd};
      bst_r <= burst_rd;
    end
    if (ctl.wait_step && fin_r) wait_r <= wait_val;
    if (ctl.turn && fin_r) turn_r <= turn_val;
  end

  // Status to the controller
  always_comb begin
    stat.is_tick   = (cmd_r == CMD_TICK);
    stat.scan_last = (scan_idx_r == N_SLOTS);
    stat.found     = found;
  end

  // Result fields
  assign out_ran              = ran_r;
  assign out_running_slot     = SLOT_W'(best_r);
  assign out_finished         = fin_r;
  assign out_wait_ticks       = PORT_TIME_W'(wait_r);
  assign out_turnaround_ticks = PORT_TIME_W'(turn_r);
  assign out_all_done         = (cnt_r == 2'd0) || ((cnt_r == 2'd1) && fin_r);
  assign out_clock_now        = PORT_TIME_W'(now_r);

endmodule

/* test/tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for the preemptive priority scheduler core.
module tb;
  import pps_pkg::*;

  localparam int SLOTS       = 16;
  localparam int GAP_MAX     = 19;
  localparam int RAND_ITEMS  = 1200;
  localparam int TAIL_CYCLES = 40;
  localparam int TICK_CAP    = 90;
  localparam int SHOW_MAX    = 10;
  localparam logic [PORT_TIME_W:0] TIME_SAT = {1'b0, {PORT_TIME_W{1'b1}}};

  typedef enum logic [1:0] {
    JOB_XACT,
    JOB_CFG,
    JOB_DRAIN
  } job_kind_t;

  typedef struct {
    job_kind_t              kind;
    cmd_t                   cmd;
    logic [SLOT_W-1:0]      slot;
    logic [PORT_TIME_W-1:0] arrival;
    logic [PORT_TIME_W-1:0] burst;
    logic [PRIO_W-1:0]      prio;
    logic [PCNT_W-1:0]      pcount;
  } job_t;

  typedef struct packed {
    logic                   ran;
    logic [SLOT_W-1:0]      slot;
    logic                   finished;
    logic [PORT_TIME_W-1:0] wait_ticks;
    logic [PORT_TIME_W-1:0] turn_ticks;
    logic                   all_done;
    logic [PORT_TIME_W-1:0] clock_now;
  } sched_out_t;

  logic                   clk         = 1'b0;
  logic                   rst_n       = 1'b0;
  logic                   start       = 1'b0;
  logic                   busy;
  logic [CMD_W-1:0]       in_command  = CMD_NOP;
  logic [SLOT_W-1:0]      in_slot     = '0;
  logic [PORT_TIME_W-1:0] in_arrival  = '0;
  logic [PORT_TIME_W-1:0] in_burst    = '0;
  logic [PRIO_W-1:0]      in_prio     = '0;
  logic                   out_strobe;
  logic                   out_ran;
  logic [SLOT_W-1:0]      out_running_slot;
  logic                   out_finished;
  logic [PORT_TIME_W-1:0] out_wait_ticks;
  logic [PORT_TIME_W-1:0] out_turnaround_ticks;
  logic                   out_all_done;
  logic [PORT_TIME_W-1:0] out_clock_now;
  logic                   cfg_wr_en   = 1'b0;
  logic [PCNT_W-1:0]      cfg_wr_data = '0;

  // Scheduler state as predicted by the testbench
  logic [PORT_TIME_W-1:0] sc_arrival [SLOTS];
  logic [PORT_TIME_W-1:0] sc_burst   [SLOTS];
  logic [PORT_TIME_W-1:0] sc_left    [SLOTS];
  logic [PRIO_W-1:0]      sc_prio    [SLOTS];
  logic [PORT_TIME_W-1:0] sc_clock;
  logic [SLOT_W-1:0]      sc_cur;
  logic                   sc_cur_valid;
  logic [PCNT_W-1:0]      sc_done;
  logic [PCNT_W-1:0]      sc_pcount;

  job_t       job_q[$];
  sched_out_t expected_q[$];
  job_t       held_job;
  int         gap_left     = 0;
  logic       no_gaps      = 1'b0;
  int         issued       = 0;
  int         results_seen = 0;
  int         fail_count   = 0;
  int         n_tick = 0, n_idle = 0, n_done = 0, n_load = 0, n_restart = 0, n_cfg = 0;

  preemptive_priority_scheduler_core dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .start                (start),
    .busy                 (busy),
    .in_command           (in_command),
    .in_slot              (in_slot),
    .in_arrival           (in_arrival),
    .in_burst             (in_burst),
    .in_prio              (in_prio),
    .out_strobe           (out_strobe),
    .out_ran              (out_ran),
    .out_running_slot     (out_running_slot),
    .out_finished         (out_finished),
    .out_wait_ticks       (out_wait_ticks),
    .out_turnaround_ticks (out_turnaround_ticks),
    .out_all_done         (out_all_done),
    .out_clock_now        (out_clock_now),
    .cfg_wr_en            (cfg_wr_en),
    .cfg_wr_data          (cfg_wr_data)
  );

  always #5 clk = ~clk;

  function automatic int slots_in_use();
    return (sc_pcount > SLOTS) ? SLOTS : int'(sc_pcount);
  endfunction

  // A slot may run when it is in use, has arrived and still has work
  function automatic logic ready_to_run(input int i);
    return (i < slots_in_use()) && (sc_left[i] != '0) && (sc_arrival[i] <= sc_clock);
  endfunction

  // Apply one transaction to the predicted state and return its result
  function automatic sched_out_t schedule_step(input job_t j);
    sched_out_t             r;
    logic                   found;
    int                     pick;
    logic [PRIO_W-1:0]      pick_prio;
    logic [PORT_TIME_W:0]   finish_at;
    logic [PORT_TIME_W:0]   owed;
    logic [PORT_TIME_W:0]   late;
    logic [PORT_TIME_W:0]   turn;
    r = '0;
    r.clock_now = sc_clock;
    case (j.cmd)
      CMD_LOAD: begin
        sc_arrival[j.slot] = j.arrival;
        sc_burst[j.slot]   = j.burst;
        sc_prio[j.slot]    = j.prio;
        sc_left[j.slot]    = j.burst;
      end
      CMD_RESTART: begin
        sc_clock     = '0;
        sc_cur       = '0;
        sc_cur_valid = 1'b0;
        sc_done      = '0;
        for (int i = 0; i < SLOTS; i++) sc_left[i] = sc_burst[i];
      end
      CMD_TICK: begin
        found     = 1'b0;
        pick      = 0;
        pick_prio = '0;
        // keep the current process unless something strictly better is ready
        if (sc_cur_valid && ready_to_run(sc_cur)) begin
          found     = 1'b1;
          pick      = sc_cur;
          pick_prio = sc_prio[sc_cur];
        end
        for (int i = 0; i < SLOTS; i++) begin
          if (ready_to_run(i) && (!found || sc_prio[i] < pick_prio)) begin
            found     = 1'b1;
            pick      = i;
            pick_prio = sc_prio[i];
          end
        end
        if (found) begin
          r.ran        = 1'b1;
          r.slot       = SLOT_W'(pick);
          sc_cur       = SLOT_W'(pick);
          sc_cur_valid = 1'b1;
          sc_left[pick] = sc_left[pick] - 1'b1;
          // report waiting and turnaround time on completion
          if (sc_left[pick] == '0) begin
            finish_at = {1'b0, sc_clock} + 1'b1;
            owed      = {1'b0, sc_arrival[pick]} + {1'b0, sc_burst[pick]};
            late      = (finish_at > owed) ? finish_at - owed : '0;
            if (late > TIME_SAT) late = TIME_SAT;
            turn = late + {1'b0, sc_burst[pick]};
            if (turn > TIME_SAT) turn = TIME_SAT;
            r.finished   = 1'b1;
            r.wait_ticks = late[PORT_TIME_W-1:0];
            r.turn_ticks = turn[PORT_TIME_W-1:0];
            sc_cur_valid = 1'b0;
            sc_cur       = '0;
            if (sc_done != '1) sc_done = sc_done + 1'b1;
          end
        end else begin
          sc_cur_valid = 1'b0;
          sc_cur       = '0;
        end
        if (sc_clock != '1) sc_clock = sc_clock + 1'b1;
      end
      default: ;
    endcase
    r.all_done = 1'b1;
    for (int i = 0; i < slots_in_use(); i++) begin
      if (sc_left[i] != '0) r.all_done = 1'b0;
    end
    return r;
  endfunction

  task automatic add_xact(input cmd_t c, input int s, input int a, input int b, input int p);
    job_t j;
    j.kind    = JOB_XACT;
    j.cmd     = c;
    j.slot    = SLOT_W'(s);
    j.arrival = PORT_TIME_W'(a);
    j.burst   = PORT_TIME_W'(b);
    j.prio    = PRIO_W'(p);
    j.pcount  = '0;
    job_q.push_back(j);
  endtask

  task automatic add_ctl(input job_kind_t k, input int v);
    job_t j;
    j.kind    = k;
    j.cmd     = CMD_NOP;
    j.slot    = '0;
    j.arrival = '0;
    j.burst   = '0;
    j.prio    = '0;
    j.pcount  = PCNT_W'(v);
    job_q.push_back(j);
  endtask

  task automatic add_tick();
    add_xact(CMD_TICK, $urandom_range(0, SLOTS - 1), $urandom_range(0, 65535),
             $urandom_range(0, 65535), $urandom_range(0, 255));
  endtask

  // Driver: launch transactions, apply idle gaps, write the register when idle
  always @(posedge clk) begin : drive
    logic       go;
    logic       cfg_go;
    sched_out_t pred;
    if (!rst_n) begin
      start     <= 1'b0;
      cfg_wr_en <= 1'b0;
    end else begin
      go     = start;
      cfg_go = 1'b0;
      if (start && !busy) begin
        pred = schedule_step(held_job);
        expected_q.push_back(pred);
        issued++;
        case (held_job.cmd)
          CMD_TICK: begin
            n_tick++;
            if (!pred.ran) n_idle++;
            if (pred.finished) n_done++;
          end
          CMD_LOAD:    n_load++;
          CMD_RESTART: n_restart++;
          default: ;
        endcase
        go = 1'b0;
        if ($urandom_range(0, 39) == 0) no_gaps = !no_gaps;
        gap_left = no_gaps ? 0 : $urandom_range(0, GAP_MAX);
      end
      if (!go) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (job_q.size() > 0) begin
          if (job_q[0].kind == JOB_XACT) begin
            held_job   = job_q.pop_front();
            go         = 1'b1;
            in_command <= held_job.cmd;
            in_slot    <= held_job.slot;
            in_arrival <= held_job.arrival;
            in_burst   <= held_job.burst;
            in_prio    <= held_job.prio;
          end else if (issued == results_seen && !busy && !start) begin
            // hold control entries until every result is in and the block is idle
            if (job_q[0].kind == JOB_CFG) begin
              cfg_go      = 1'b1;
              cfg_wr_data <= job_q[0].pcount;
              sc_pcount   = job_q[0].pcount;
              n_cfg++;
            end
            void'(job_q.pop_front());
          end
        end
      end
      start     <= go;
      cfg_wr_en <= cfg_go;
    end
  end

  // Monitor: compare each strobed result with the oldest expectation
  always @(posedge clk) begin : watch
    sched_out_t seen;
    sched_out_t want;
    if (rst_n && out_strobe) begin
      seen = {out_ran, out_running_slot, out_finished, out_wait_ticks,
              out_turnaround_ticks, out_all_done, out_clock_now};
      if (expected_q.size() == 0) begin
        if (fail_count < SHOW_MAX) $display("%0t: result with no transaction pending", $time);
        fail_count++;
      end else begin
        want = expected_q.pop_front();
        if (seen !== want) begin
          if (fail_count < SHOW_MAX) begin
            $write("%0t: mismatch exp/act ran %0b/%0b slot %0d/%0d fin %0b/%0b ",
                   $time, want.ran, seen.ran, want.slot, seen.slot,
                   want.finished, seen.finished);
            $display("wait %0d/%0d turn %0d/%0d done %0b/%0b clock %0d/%0d",
                     want.wait_ticks, seen.wait_ticks,
                     want.turn_ticks, seen.turn_ticks, want.all_done, seen.all_done,
                     want.clock_now, seen.clock_now);
          end
          fail_count++;
        end
      end
      results_seen <= results_seen + 1;
    end
  end

  initial begin : run
    int   pc, in_use, work, latest, ticks, a, b, p, rand_items;
    logic tight;
    cmd_t c;

    // reset state of the predicted scheduler
    for (int i = 0; i < SLOTS; i++) sc_left[i] = '0;
    sc_clock     = '0;
    sc_cur       = '0;
    sc_cur_valid = 1'b0;
    sc_done      = '0;
    sc_pcount    = PCNT_W'(1);

    // directed: fill every slot first so no entry is ever read unwritten
    add_xact(CMD_LOAD, 0, 0, 2, 5);
    add_xact(CMD_LOAD, 1, 1, 1, 0);                 // arrives later and preempts slot 0
    add_xact(CMD_LOAD, 2, 0, 0, 0);                 // zero burst, never runs
    add_xact(CMD_LOAD, 3, 16'hFFFF, 16'hFFFF, 8'hFF);
    for (int s = 4; s < SLOTS; s++) add_xact(CMD_LOAD, s, 2, 1, 7);  // ties go to lowest slot
    add_tick();                                     // reset count: one slot in use
    add_ctl(JOB_CFG, SLOTS);
    add_xact(CMD_RESTART, 0, 0, 0, 0);
    repeat (5) add_tick();
    add_xact(CMD_NOP, 15, 16'hFFFF, 16'hFFFF, 8'hFF);
    add_ctl(JOB_CFG, 0);
    add_tick();
    add_ctl(JOB_CFG, 31);
    add_tick();

    // random: workloads of small processes, with preemption, noise and count changes
    rand_items = 0;
    add_ctl(JOB_DRAIN, 0);
    while (rand_items < RAND_ITEMS) begin
      case ($urandom_range(0, 9))
        0:       pc = 0;
        1:       pc = $urandom_range(SLOTS + 1, 31);
        2:       pc = SLOTS;
        default: pc = $urandom_range(1, SLOTS);
      endcase
      add_ctl(JOB_CFG, pc);
      in_use = (pc > SLOTS) ? SLOTS : pc;
      work   = 0;
      latest = 0;
      tight  = $urandom_range(0, 1);
      for (int s = 0; s < SLOTS; s++) begin
        if ($urandom_range(0, 4) != 0) begin
          a = $urandom_range(0, 12);
          b = ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 5);
          p = tight ? $urandom_range(0, 3) : $urandom_range(0, 255);
          add_xact(CMD_LOAD, s, a, b, p);
          rand_items++;
          if (s < in_use) begin
            work += b;
            if (a > latest) latest = a;
          end
        end
      end
      if ($urandom_range(0, 3) != 0) begin
        add_xact(CMD_RESTART, $urandom_range(0, SLOTS - 1), $urandom_range(0, 65535),
                 $urandom_range(0, 65535), $urandom_range(0, 255));
        rand_items++;
      end
      ticks = work + latest + $urandom_range(0, 4);
      if (ticks > TICK_CAP) ticks = TICK_CAP;
      for (int t = 0; t < ticks; t++) begin
        case ($urandom_range(0, 39))
          0, 1: begin
            add_xact(CMD_LOAD, $urandom_range(0, SLOTS - 1), $urandom_range(0, 20),
                     $urandom_range(1, 4), $urandom_range(0, 255));
            rand_items++;
          end
          2: add_xact(CMD_NOP, $urandom_range(0, SLOTS - 1), $urandom_range(0, 65535),
                      $urandom_range(0, 65535), $urandom_range(0, 255));
          3: add_ctl(JOB_CFG, $urandom_range(0, 31));
          4, 5, 6: begin
            c = cmd_t'($urandom_range(0, 3));
            add_xact(c, $urandom_range(0, SLOTS - 1), $urandom_range(0, 65535),
                     $urandom_range(0, 65535), $urandom_range(0, 255));
            if (c != CMD_NOP) rand_items++;
          end
          default: ;
        endcase
        add_tick();
        rand_items++;
      end
      if ($urandom_range(0, 7) == 0) add_ctl(JOB_DRAIN, 0);
    end

    // release reset and let the driver work through the queue
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    do begin
      @(posedge clk);
      #1;
    end while (job_q.size() != 0 || start || issued != results_seen);
    repeat (TAIL_CYCLES) @(posedge clk);
    #1;
    if (expected_q.size() != 0) fail_count++;

    $display("Ran %0d transactions: %0d ticks (%0d idle, %0d completions), %0d loads,",
             issued, n_tick, n_idle, n_done, n_load);
    $display("%0d restarts and %0d process_count writes; %0d failures.",
             n_restart, n_cfg, fail_count);
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Watchdog: end the run if the block stops answering
  initial begin : watchdog
    #5_000_000;
    $display("FAIL");
    $finish;
  end

endmodule

/* filelist.f */
src/pps_pkg.sv
src/pps_ram.sv
src/pps_ctrl.sv
src/pps_datapath.sv
src/preemptive_priority_scheduler_core.sv
test/tb.sv
